// ===== rtl/htpi_pkg.sv =====
`timescale 1ns / 1ps

package htpi_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PROBE_W       = IDX_W - 1;

    // Key and value geometry
    localparam int KEY_BYTES  = 8;
    localparam int KEY_W      = 64;
    localparam int LEN_W      = 4;
    localparam int BYTE_SEL_W = 3;
    localparam int VALUE_BITS = 32;
    localparam int VALUE_W    = 32;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int HASH_W     = 32;

    // FNV-1a 32-bit constants
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Request item
    typedef struct packed {
        logic               operation;
        logic [KEY_W-1:0]   key_bytes;
        logic [LEN_W-1:0]   key_length;
        logic [VALUE_W-1:0] value;
    } req_t;

    // Response item
    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] value_out;
        logic [SLOT_W-1:0]  slot;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic hash_step;
        logic rd_issue;
        logic capture;
        logic advance;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hash_done;
        logic hit;
        logic free;
        logic last;
        logic insert;
        logic out_free;
    } stat_t;

    // Clamp the key length to the key width
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = (len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len;
        return res;
    endfunction

    // Byte mask keeping the first len bytes
    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            m[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/hash_table_probe_insert_unit.sv =====
`timescale 1ns / 1ps

// Open-addressing key/value table, 16 slots, FNV-1a hash, quadratic probing.
// Request channel (req_valid / req_stall / req): one item per lookup or
// insert; an item is taken when req_valid is high and req_stall is low.
// req_stall is low only while the unit is idle; one item is worked at a time.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one item per
// request, held in an output register until taken.
// After a request is accepted, the unit runs L hash rounds, where L is the
// key length capped at 8, through the single 32-bit multiplier, then a read
// and a compare step for each of P (1 to 8) slots probed on the slot memory's
// registered read port.
// While the receiver stalls, the result waits in the output register and the
// next request can be taken and processed; if it finishes before the old
// result leaves, it waits in its done state.
// Reset clears all used marks at once (the table is empty) and the output
// valid; the stored keys and values need no clearing.
module hash_table_probe_insert_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  htpi_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output htpi_pkg::rsp_t rsp
);
    import htpi_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    htpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    htpi_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/htpi_dpath.sv =====
`timescale 1ns / 1ps

module htpi_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  htpi_pkg::req_t  req,
    input  htpi_pkg::cmd_t  cmd,
    input  logic            rsp_stall,
    output htpi_pkg::stat_t stat,
    output logic            rsp_valid,
    output htpi_pkg::rsp_t  rsp
);
    import htpi_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [LEN_W-1:0]      len;
        logic [HASH_W-1:0]     hash;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    // Slot store: one write port, one registered read port
    entry_t mem [TABLE_ENTRIES];

    logic                  op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [HASH_W-1:0]     hash_reg, hash_next;
    logic [LEN_W-1:0]      cnt_reg, cnt_next;
    logic [PROBE_W-1:0]    probe_reg, probe_next;
    logic [IDX_W-1:0]      idx_reg;
    entry_t                rd_reg;
    logic [TABLE_ENTRIES-1:0] used_reg;
    rsp_t                  res_reg, res_next;
    rsp_t                  rsp_reg;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic [LEN_W-1:0]      len_in;
    logic [KEY_W-1:0]      key_in;
    logic [7:0]            byte_cur;
    logic [HASH_W-1:0]     mixed;
    logic [2*PROBE_W-1:0]  probe_sq;
    logic [IDX_W-1:0]      probe_idx;
    logic                  used_cur;
    logic                  hit;
    logic                  wr_en;
    entry_t                wr_entry;

    // Request normalization
    assign len_in = sat_len(req.key_length);
    assign key_in = req.key_bytes & key_mask(len_in);

    // One FNV-1a round per cycle
    assign byte_cur = key_reg[cnt_reg[BYTE_SEL_W-1:0]*8 +: 8];
    assign mixed    = hash_reg ^ {{(HASH_W-8){1'b0}}, byte_cur};

    always_comb
    begin
        hash_next  = hash_reg;
        cnt_next   = cnt_reg;
        probe_next = probe_reg;
        if (cmd.load)
        begin
            hash_next  = FNV_BASIS;
            cnt_next   = '0;
            probe_next = '0;
        end
        else if (cmd.hash_step)
        begin
            hash_next = mixed * FNV_PRIME;
            cnt_next  = cnt_reg + 1'b1;
        end
        else if (cmd.advance)
        begin
            probe_next = probe_reg + 1'b1;
        end
    end

    // Quadratic probe address
    assign probe_sq  = probe_reg * probe_reg;
    assign probe_idx = hash_reg[IDX_W-1:0] + IDX_W'(probe_sq);

    // Slot compare
    assign used_cur = used_reg[idx_reg];
    assign hit = used_cur && (rd_reg.hash == hash_reg) && (rd_reg.len == len_reg)
                 && (rd_reg.key == key_reg);
    assign wr_en = cmd.capture && op_reg && (hit || !used_cur);

    assign wr_entry.key   = key_reg;
    assign wr_entry.len   = len_reg;
    assign wr_entry.hash  = hash_reg;
    assign wr_entry.value = val_reg;

    // Result of the probe under test
    always_comb
    begin
        res_next.status    = op_reg ? ST_FULL : ST_MISS;
        res_next.value_out = '0;
        res_next.slot      = '0;
        if (hit)
        begin
            res_next.status    = ST_FOUND;
            res_next.value_out = op_reg ? VALUE_W'(val_reg) : VALUE_W'(rd_reg.value);
            res_next.slot      = SLOT_W'(idx_reg);
        end
        else if (!used_cur && op_reg)
        begin
            res_next.status    = ST_NEW;
            res_next.value_out = VALUE_W'(val_reg);
            res_next.slot      = SLOT_W'(idx_reg);
        end
    end

    // Output register handshake
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.operation;
            key_reg <= key_in;
            len_reg <= len_in;
            val_reg <= VALUE_BITS'(req.value);
        end
        hash_reg  <= hash_next;
        cnt_reg   <= cnt_next;
        probe_reg <= probe_next;
        if (cmd.rd_issue)
        begin
            idx_reg <= probe_idx;
        end
        if (cmd.capture)
        begin
            res_reg <= res_next;
        end
        // Finished result moves to the output only when the output is free
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    // Slot store
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_reg <= mem[probe_idx];
        end
        if (wr_en)
        begin
            mem[idx_reg] <= wr_entry;
        end
    end

    // Used marks and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (wr_en)
            begin
                used_reg[idx_reg] <= 1'b1;
            end
        end
    end

    assign stat.hash_done = (cnt_reg == len_reg);
    assign stat.hit       = hit;
    assign stat.free      = !used_cur;
    assign stat.last      = &probe_reg;
    assign stat.insert    = op_reg;
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A response is never loaded over one still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response overwritten while stalled");

    // Hash rounds stop at the key length
    a_hash_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hash_step |-> (cnt_reg < len_reg))
        else $error("hash round past key length");

    // A reported new slot is marked used
    a_new_used: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ST_NEW)) |-> used_reg[IDX_W'(rsp_reg.slot)])
        else $error("new slot not marked used");

endmodule

// ===== rtl/htpi_ctrl.sv =====
`timescale 1ns / 1ps

module htpi_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  htpi_pkg::stat_t stat,
    output logic            req_stall,
    output htpi_pkg::cmd_t  cmd
);
    import htpi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (stat.hash_done)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.hit || (stat.free && stat.insert) || stat.last)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // A finished probe always hands its result to the output stage
    a_capture_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_DONE))
        else $error("capture not followed by done");

    // A blocked result waits in place
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !stat.out_free) |=> (state_reg == S_DONE))
        else $error("result dropped while output busy");

endmodule
